// ===== rtl/closest_point_on_segment_3d_defines.svh =====
// Assertion helpers for the top-level RTL file.
`ifndef CLOSEST_POINT_ON_SEGMENT_3D_DEFINES_SVH
`define CLOSEST_POINT_ON_SEGMENT_3D_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define CPSEG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define CPSEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cpseg_pkg.sv =====
package cpseg_pkg;

  // Coordinate width and the derived datapath widths.
  localparam int CW = 32;
  localparam int DW = CW + 1;          // endpoint difference
  localparam int PW = 2 * DW;          // one product of differences
  localparam int SW = PW + 2;          // sum of three products
  localparam int UW = SW - 1;          // magnitude of dot or len2 when positive
  localparam int LW = (UW + 1) / 2;    // low slice of dot for the split multiply
  localparam int HW = UW - LW;         // high slice of dot
  localparam int NW = UW + CW;         // dot times |d|
  localparam int QW = CW;              // quotient bits, one divider step each
  localparam int RW = UW + 1;          // trial remainder

  // Region codes.
  localparam logic [1:0] REG_INTERIOR = 2'd0;
  localparam logic [1:0] REG_START    = 2'd1;
  localparam logic [1:0] REG_END      = 2'd2;
  localparam logic [1:0] REG_DEGEN    = 2'd3;

  // Fields carried alongside the divider.
  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] b;
    logic [1:0]         region;
    logic [2:0]         dneg;
  } side_t;

endpackage

// ===== rtl/cpseg_dot.sv =====
module cpseg_dot (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2:0][cpseg_pkg::CW-1:0] a,
  input  logic [2:0][cpseg_pkg::CW-1:0] b,
  input  logic [2:0][cpseg_pkg::CW-1:0] p,
  output logic                          valid,
  output logic [cpseg_pkg::SW-1:0]      dot,
  output logic [cpseg_pkg::SW-1:0]      len2,
  output logic [2:0][cpseg_pkg::DW-1:0] d,
  output logic [2:0][cpseg_pkg::CW-1:0] a_out,
  output logic [2:0][cpseg_pkg::CW-1:0] b_out
);
  import cpseg_pkg::*;

  logic                v1, v2, v3;
  logic [2:0][DW-1:0]  d1, e1, d2;
  logic [2:0][CW-1:0]  a1, b1, a2, b2, a3, b3;
  logic [2:0][PW-1:0]  dd2, de2;
  logic [SW-1:0]       dot3, len3;
  logic [2:0][DW-1:0]  d3;

  // Valid bits advance with the pipeline enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: differences; stage 2: products; stage 3: sums.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1[i]  <= {b[i][CW-1], b[i]} - {a[i][CW-1], a[i]};
        e1[i]  <= {p[i][CW-1], p[i]} - {a[i][CW-1], a[i]};
        a1[i]  <= a[i];
        b1[i]  <= b[i];
        dd2[i] <= $signed(d1[i]) * $signed(d1[i]);
        de2[i] <= $signed(d1[i]) * $signed(e1[i]);
        d2[i]  <= d1[i];
        a2[i]  <= a1[i];
        b2[i]  <= b1[i];
        d3[i]  <= d2[i];
        a3[i]  <= a2[i];
        b3[i]  <= b2[i];
      end
      dot3 <= {{2{de2[0][PW-1]}}, de2[0]} + {{2{de2[1][PW-1]}}, de2[1]}
            + {{2{de2[2][PW-1]}}, de2[2]};
      len3 <= {2'b00, dd2[0]} + {2'b00, dd2[1]} + {2'b00, dd2[2]};
    end
  end

  assign valid = v3;
  assign dot   = dot3;
  assign len2  = len3;
  assign d     = d3;
  assign a_out = a3;
  assign b_out = b3;

endmodule

// ===== rtl/cpseg_scale.sv =====
module cpseg_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [cpseg_pkg::SW-1:0]      dot,
  input  logic [cpseg_pkg::SW-1:0]      len2,
  input  logic [2:0][cpseg_pkg::DW-1:0] d,
  input  logic [2:0][cpseg_pkg::CW-1:0] a,
  input  logic [2:0][cpseg_pkg::CW-1:0] b,
  output logic                          valid,
  output logic [2:0][cpseg_pkg::NW-1:0] num,
  output logic [cpseg_pkg::UW-1:0]      len2_out,
  output cpseg_pkg::side_t              side
);
  import cpseg_pkg::*;

  logic                     v4, v5;
  logic [1:0]               region;
  logic [2:0][CW-1:0]       magd;
  logic [2:0][DW-1:0]       negd;
  logic [2:0][LW+CW-1:0]    plo4;
  logic [2:0][HW+CW-1:0]    phi4;
  logic [UW-1:0]            len4, len5;
  side_t                    side_c, side4, side5;
  logic [2:0][NW-1:0]       num5;

  // Classify against the segment ends without a square root.
  always_comb begin
    if (len2 == '0) begin
      region = REG_DEGEN;
    end else if (dot[SW-1] || dot == '0) begin
      region = REG_START;
    end else if ($signed(dot) >= $signed(len2)) begin
      region = REG_END;
    end else begin
      region = REG_INTERIOR;
    end
  end

  // Magnitude and sign of each axis difference.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      negd[i] = -d[i];
      magd[i] = d[i][DW-1] ? negd[i][CW-1:0] : d[i][CW-1:0];
    end
    side_c.a      = a;
    side_c.b      = b;
    side_c.region = region;
    side_c.dneg   = {d[2][DW-1], d[1][DW-1], d[0][DW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
    end
  end

  // Stage 4: split multiply of dot by |d|; stage 5: recombine the halves.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        plo4[i] <= dot[LW-1:0] * magd[i];
        phi4[i] <= dot[UW-1:LW] * magd[i];
        num5[i] <= {{(NW-LW-CW){1'b0}}, plo4[i]} + {phi4[i], {LW{1'b0}}};
      end
      len4  <= len2[UW-1:0];
      side4 <= side_c;
      len5  <= len4;
      side5 <= side4;
    end
  end

  assign valid    = v5;
  assign num      = num5;
  assign len2_out = len5;
  assign side     = side5;

endmodule

// ===== rtl/cpseg_div.sv =====
module cpseg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2:0][cpseg_pkg::NW-1:0] num,
  input  logic [cpseg_pkg::UW-1:0]      len2,
  input  cpseg_pkg::side_t              side_in,
  output logic                          valid,
  output logic [2:0][cpseg_pkg::QW-1:0] quo,
  output cpseg_pkg::side_t              side
);
  import cpseg_pkg::*;

  // One restoring division step per stage, three lanes in parallel.
  logic               vq     [QW];
  logic [2:0][UW-1:0] rem_q  [QW];
  logic [2:0][QW-1:0] low_q  [QW];
  logic [2:0][QW-1:0] quo_q  [QW];
  logic [UW-1:0]      len_q  [QW];
  side_t              side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [2:0][UW-1:0] rin;
    logic [2:0][QW-1:0] lin, qin;
    logic [UW-1:0]      lin2;
    side_t              sin;
    logic               vin;
    logic [2:0][RW-1:0] trial, diff;
    logic [2:0]         ge;

    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rin[i] = num[i][NW-1:QW];
          lin[i] = num[i][QW-1:0];
          qin[i] = '0;
        end
        lin2 = len2;
        sin  = side_in;
        vin  = in_valid;
      end
    end else begin : g_next
      always_comb begin
        rin  = rem_q[k-1];
        lin  = low_q[k-1];
        qin  = quo_q[k-1];
        lin2 = len_q[k-1];
        sin  = side_q[k-1];
        vin  = vq[k-1];
      end
    end

    // Bring down the next dividend bit and try a subtract.
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rin[i], lin[i][QW-1]};
        diff[i]  = trial[i] - {1'b0, lin2};
        ge[i]    = trial[i] >= {1'b0, lin2};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (en) begin
        vq[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i] <= ge[i] ? diff[i][UW-1:0] : trial[i][UW-1:0];
          low_q[k][i] <= {lin[i][QW-2:0], 1'b0};
          quo_q[k][i] <= {qin[i][QW-2:0], ge[i]};
        end
        len_q[k]  <= lin2;
        side_q[k] <= sin;
      end
    end
  end

  assign valid = vq[QW-1];
  assign quo   = quo_q[QW-1];
  assign side  = side_q[QW-1];

endmodule

// ===== rtl/closest_point_on_segment_3d.sv =====
// Closest point on a 3-D segment: each beat carries A, B and P; the result beat carries the
// point of segment AB nearest to P and a region code (interior, start, end, degenerate).
// The block is a fixed pipeline that takes one beat per cycle with no gaps while the result side
// does not stall; each beat passes through the dot-product stages, the split multiply, the
// one-bit-per-stage quotient and the output register. Back-pressure on the result side stalls
// the whole pipeline, so s_axis_tready is high while the output register is empty or m_axis_tready is high.
module closest_point_on_segment_3d (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z, 32 bits each from bit 0 up
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // c_x, c_y, c_z, 32 bits each from bit 0 up
  output logic [95:0]  m_axis_tdata,
  // region
  output logic [1:0]   m_axis_tuser
);
  import cpseg_pkg::*;
`include "closest_point_on_segment_3d_defines.svh"

  logic               en;
  logic [2:0][CW-1:0] in_a, in_b, in_p;
  logic               dot_valid, scale_valid, div_valid;
  logic [SW-1:0]      dot, len2;
  logic [2:0][DW-1:0] d;
  logic [2:0][CW-1:0] dot_a, dot_b;
  logic [2:0][NW-1:0] num;
  logic [UW-1:0]      len2_s;
  side_t              scale_side, div_side;
  logic [2:0][QW-1:0] quo;
  logic [2:0][CW+1:0] sum;
  logic [2:0][CW-1:0] c_next;
  logic               out_valid;
  logic [2:0][CW-1:0] c_out;
  logic [1:0]         region_out;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_axis_tdata[i*CW +: CW];
      in_b[i] = s_axis_tdata[(3+i)*CW +: CW];
      in_p[i] = s_axis_tdata[(6+i)*CW +: CW];
    end
  end

  cpseg_dot u_dot (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .a        (in_a),
    .b        (in_b),
    .p        (in_p),
    .valid    (dot_valid),
    .dot      (dot),
    .len2     (len2),
    .d        (d),
    .a_out    (dot_a),
    .b_out    (dot_b)
  );

  cpseg_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (dot_valid),
    .dot      (dot),
    .len2     (len2),
    .d        (d),
    .a        (dot_a),
    .b        (dot_b),
    .valid    (scale_valid),
    .num      (num),
    .len2_out (len2_s),
    .side     (scale_side)
  );

  cpseg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (scale_valid),
    .num      (num),
    .len2     (len2_s),
    .side_in  (scale_side),
    .valid    (div_valid),
    .quo      (quo),
    .side     (div_side)
  );

  // Offset from A with the sign of the axis difference, saturated, then region select.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_side.dneg[i]) begin
        sum[i] = {{2{div_side.a[i][CW-1]}}, div_side.a[i]} - {2'b00, quo[i]};
      end else begin
        sum[i] = {{2{div_side.a[i][CW-1]}}, div_side.a[i]} + {2'b00, quo[i]};
      end
      case (div_side.region)
        REG_INTERIOR: begin
          if (sum[i][CW+1] != sum[i][CW-1] || sum[i][CW] != sum[i][CW-1]) begin
            c_next[i] = sum[i][CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
          end else begin
            c_next[i] = sum[i][CW-1:0];
          end
        end
        REG_END: c_next[i] = div_side.b[i];
        default: c_next[i] = div_side.a[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_out      <= c_next;
      region_out <= div_side.region;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = c_out;
  assign m_axis_tuser  = region_out;

  // A beat leaving the divider while the pipeline moves lands in the output register.
  `CPSEG_ASSERT_NEXT(a_div_to_out, en && div_valid, out_valid, "divider beat lost")
  // Degenerate code only when the endpoints match.
  `CPSEG_ASSERT_NOW(a_degen_eq, div_valid && div_side.region == REG_DEGEN, div_side.a == div_side.b, "degenerate code on distinct endpoints")
  // An interior point needs distinct endpoints.
  `CPSEG_ASSERT_NOW(a_interior_ne, div_valid && div_side.region == REG_INTERIOR, div_side.a != div_side.b, "interior code on a degenerate segment")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cpseg_pkg::*;

  typedef struct packed {
    logic signed [31:0] pz, py, px, bz, by, bx, az, ay, ax;
  } query_t;

  typedef struct packed {
    logic [1:0]         region;
    logic signed [31:0] cz, cy, cx;
  } nearest_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         s_axis_tready_q = 1'b0;

  query_t   pending_q[$];
  nearest_t expected_q[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_send = 1'b0;
  int       errors = 0;
  longint   cycle_count = 0;

  closest_point_on_segment_3d i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Nearest point on AB to P, using exact wide dot products.
  function automatic nearest_t nearest_point(query_t q);
    logic signed [32:0]  d[3];
    logic signed [32:0]  e[3];
    logic signed [31:0]  av[3];
    logic signed [31:0]  bv[3];
    logic signed [31:0]  pv[3];
    logic signed [69:0]  dot;
    logic signed [69:0]  len2;
    logic signed [103:0] num;
    logic signed [103:0] quo;
    nearest_t r;
    av = '{q.ax, q.ay, q.az};
    bv = '{q.bx, q.by, q.bz};
    pv = '{q.px, q.py, q.pz};
    dot = '0;
    len2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 33'(bv[i]) - 33'(av[i]);
      e[i] = 33'(pv[i]) - 33'(av[i]);
      dot = dot + 70'(d[i]) * 70'(e[i]);
      len2 = len2 + 70'(d[i]) * 70'(d[i]);
    end
    if (len2 == 0) begin
      r = '{REG_DEGEN, q.az, q.ay, q.ax};
    end else if (dot <= 0) begin
      r = '{REG_START, q.az, q.ay, q.ax};
    end else if (dot >= len2) begin
      r = '{REG_END, q.bz, q.by, q.bx};
    end else begin
      r.region = REG_INTERIOR;
      for (int i = 0; i < 3; i++) begin
        // Signed division truncates toward zero, as required.
        num = 104'(d[i]) * 104'(dot);
        quo = num / 104'(len2);
        av[i] = 32'(104'(av[i]) + quo);
      end
      r.cx = av[0];
      r.cy = av[1];
      r.cz = av[2];
    end
    return r;
  endfunction

  // Driver: feeds queued beats, changing inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (pending_q.size() > 0 && !hold_send &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          s_axis_tdata <= pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Input acceptance and output checking at the rising edge.
  always @(posedge clk) begin
    nearest_t got;
    nearest_t want;
    cycle_count <= cycle_count + 1;
    s_axis_tready_q <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(nearest_point(query_t'(s_axis_tdata)));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.cx !== want.cx) begin
            $display("%0t: c_x expected %h got %h", $time, want.cx, got.cx);
            errors++;
          end
          if (got.cy !== want.cy) begin
            $display("%0t: c_y expected %h got %h", $time, want.cy, got.cy);
            errors++;
          end
          if (got.cz !== want.cz) begin
            $display("%0t: c_z expected %h got %h", $time, want.cz, got.cz);
            errors++;
          end
          if (got.region !== want.region) begin
            $display("%0t: region expected %0d got %0d", $time, want.region, got.region);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] pick_coord(int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(4000, 0)) - 2000) <<< 12;
      default: return $urandom;
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    int mode;
    mode = $urandom_range(9, 0);
    q.ax = pick_coord(mode < 2 ? 3 : $urandom_range(3, 2));
    q.ay = pick_coord(mode < 2 ? 3 : $urandom_range(3, 2));
    q.az = pick_coord(mode < 2 ? 3 : $urandom_range(3, 2));
    q.bx = pick_coord($urandom_range(9, 0) == 0 ? $urandom_range(1, 0) : $urandom_range(3, 2));
    q.by = pick_coord($urandom_range(3, 2));
    q.bz = pick_coord($urandom_range(3, 2));
    // Mostly points near the segment so interior results dominate.
    if (mode < 7) begin
      q.px = q.ax + ((q.bx - q.ax) >>> 1) + pick_coord(2);
      q.py = q.ay + ((q.by - q.ay) >>> 1) + pick_coord(2);
      q.pz = q.az + ((q.bz - q.az) >>> 1) + pick_coord(2);
    end else begin
      q.px = pick_coord($urandom_range(3, 0));
      q.py = pick_coord($urandom_range(3, 0));
      q.pz = pick_coord($urandom_range(3, 0));
    end
    if (mode == 9) begin
      q.bx = q.ax;
      q.by = q.ay;
      q.bz = q.az;
    end
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || expected_q.size() > 0 || s_axis_tvalid)
      @(posedge clk);
  endtask

  task automatic wait_sent();
    while (pending_q.size() > 0)
      @(posedge clk);
  endtask

  // Stimulus phases and end of run.
  initial begin
    query_t q;
    int idle_sets[4][2];
    idle_sets = '{'{0, 0}, '{72, 0}, '{0, 72}, '{27, 27}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: degenerate, start, end, interior, extremes.
    pending_q.push_back('{0, 0, 0, 0, 0, 0, 5, 6, 7});
    pending_q.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0});
    pending_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    pending_q.push_back('{0, 0, 32'h0001_0000, 0, 0, 32'h000a_0000, 0, 0, 0});
    pending_q.push_back('{0, 0, 32'h000a_0000, 0, 0, 32'h000a_0000, 0, 0, 0});
    pending_q.push_back('{0, 0, 32'h0003_0000, 0, 0, 32'h000a_0000, 0, 0, 0});
    pending_q.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h0000_1234, 32'h8000_0000,
                          32'h7fff_ffff, 32'hffff_0000, 32'h8000_0000, 32'h8000_0000, 0});
    pending_q.push_back('{32'hffff_ffff, 32'h7, 32'h3, 32'h1, 32'hfffffffd, 32'h5,
                          32'h0, 32'h0, 32'h0});
    pending_q.push_back('{32'h0000_0003, 0, 0, 32'h0000_0001, 0, 0, 32'hffff_ffff, 0, 0});
    pending_q.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'hffff_ffff, 0, 32'h0000_0001});
    pending_q.push_back('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                          32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    wait_drained();

    // Hold the sender until every result is back, once per phase.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_sets[ph][0];
      recv_stall_pct = idle_sets[ph][1];
      for (int n = 0; n < 240; n++) begin
        q = random_query();
        pending_q.push_back(q);
      end
      wait_sent();
      hold_send = 1'b1;
      wait_drained();
      hold_send = 1'b0;
      for (int n = 0; n < 245; n++) begin
        q = random_query();
        pending_q.push_back(q);
      end
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 10; n++) pending_q.push_back(random_query());
    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Run limit.
  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cpseg_pkg.sv
rtl/cpseg_dot.sv
rtl/cpseg_scale.sv
rtl/cpseg_div.sv
rtl/closest_point_on_segment_3d.sv
sim/tb_top.sv
